FILE: design/thcd_pkg.sv
// Shared types and constants for the deadband thermostat core.
// Used by the core and its port checker; no dependencies.
`default_nettype none
package thcd_pkg;

	localparam int NUM_BUTTONS     = 4;
	localparam int HOLD_COUNT_BITS = 9;
	localparam int DEB_W           = 8;
	localparam int DBAND_W         = 7;
	localparam int SP_W            = 7;
	localparam int CMD_W           = 3;
	localparam int TEMP_W          = 13;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 8;

	localparam int BTN_DOWN = 0;
	localparam int BTN_UP   = 1;
	localparam int BTN_MODE = 2;
	localparam int BTN_FAN  = 3;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_HEAT = 2'd1,
		MODE_COOL = 2'd2
	} mode_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE        = 3'd0,
		CMD_PRESET_HEAT = 3'd1,
		CMD_PRESET_COOL = 3'd2,
		CMD_PRESET_OFF  = 3'd3,
		CMD_STEP        = 3'd4
	} remote_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_DEADBAND = 2'd1,
		CFG_SP_MIN   = 2'd2,
		CFG_SP_MAX   = 2'd3
	} cfg_idx_t;

	localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 8'd50;
	localparam logic [DBAND_W-1:0] DEADBAND_RST = 7'd10;
	localparam logic [SP_W-1:0]    SP_MIN_RST   = 7'd40;
	localparam logic [SP_W-1:0]    SP_MAX_RST   = 7'd99;
	localparam logic [SP_W-1:0]    SP_RST       = 7'd75;
	localparam logic [SP_W-1:0]    PRESET_HEAT  = 7'd80;
	localparam logic [SP_W-1:0]    PRESET_COOL  = 7'd68;
	localparam logic [SP_W-1:0]    PRESET_OFF   = 7'd75;

	function automatic mode_t next_mode(input mode_t m);
		case (m)
			MODE_OFF:  next_mode = MODE_HEAT;
			MODE_HEAT: next_mode = MODE_COOL;
			default:   next_mode = MODE_OFF;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: design/thermostat_controller_deadband_core.sv
// Deadband thermostat core: button debounce, setpoint/mode/fan state and relay drive.
// Depends on thcd_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word per 1 ms tick: four raw
//   button levels (pressed when low), a remote command and the temperature in
//   tenths of a degree F. Output channel (out_valid/out_stall) returns one word
//   per input word: relay drives plus current setpoint, mode and forced fan.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
//   ready and take effect at once; write only while the core is idle.
//   Path: input register, then result register. Throughput: one word per cycle
//   while the output is not stalled; all state updates happen in the single step
//   between the input register and the result register.
//   Reset: state and config registers return to defaults (setpoint 75 F, mode off,
//   fan auto, debounce 50 ticks, deadband 1.0 F, limits 40..99 F); no words in flight.
//   Stall: a stalled output word holds; an occupied input register then holds and
//   in_stall rises, while the output register can still take a word in the
//   cycle it is drained.
`default_nettype none
module thermostat_controller_deadband_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [thcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [thcd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               btn_down_level,
	input  wire                               btn_up_level,
	input  wire                               btn_mode_level,
	input  wire                               btn_fan_level,
	input  wire  [thcd_pkg::CMD_W-1:0]        remote_cmd,
	input  wire  signed [thcd_pkg::TEMP_W-1:0] temp_tenths_f,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              heater_drive,
	output logic                              cooler_drive,
	output logic                              fan_drive,
	output logic [thcd_pkg::SP_W-1:0]         setpoint_now,
	output logic [1:0]                        mode_now,
	output logic                              fan_forced_now
);
	import thcd_pkg::*;

	logic [DEB_W-1:0]   debounce_q;
	logic [DBAND_W-1:0] deadband_q;
	logic [SP_W-1:0]    sp_min_q;
	logic [SP_W-1:0]    sp_max_q;

	logic [NUM_BUTTONS-1:0]     last_q;
	logic [NUM_BUTTONS-1:0]     stable_q;
	logic [HOLD_COUNT_BITS-1:0] cnt_q [NUM_BUTTONS];
	logic [SP_W-1:0]            sp_q;
	mode_t                      mode_q;
	logic                       fan_forced_q;

	logic                     valid_s1;
	logic [NUM_BUTTONS-1:0]   lvl_s1;
	logic [CMD_W-1:0]         cmd_s1;
	logic signed [TEMP_W-1:0] temp_s1;

	logic            out_valid_q;
	logic            heater_q;
	logic            cooler_q;
	logic            fan_q;
	logic [SP_W-1:0] sp_out_q;
	mode_t           mode_out_q;
	logic            fan_forced_out_q;

	logic                       advance;
	logic [NUM_BUTTONS-1:0]     stable_n;
	logic [NUM_BUTTONS-1:0]     press;
	logic [HOLD_COUNT_BITS-1:0] cnt_n [NUM_BUTTONS];
	logic [SP_W-1:0]            sp_a;
	logic [SP_W-1:0]            sp_n;
	mode_t                      mode_b;
	mode_t                      mode_n;
	logic                       fan_b;
	logic                       fan_forced_n;
	logic [10:0]                target;
	logic signed [TEMP_W:0]     t_plus;
	logic signed [TEMP_W:0]     t_minus;
	logic signed [TEMP_W:0]     target_s;
	logic                       heat_n;
	logic                       cool_n;
	logic                       fan_n;

	function automatic logic [SP_W-1:0] move_sp(input logic [SP_W-1:0] sp,
			input logic up, input logic [SP_W-1:0] lo, input logic [SP_W-1:0] hi);
		logic signed [SP_W+1:0] v;
		v = $signed({2'b00, sp}) + (up ? (SP_W+2)'(1) : -(SP_W+2)'(1));
		if (v < $signed({2'b00, lo}))
			v = $signed({2'b00, lo});
		if (v > $signed({2'b00, hi}))
			v = $signed({2'b00, hi});
		move_sp = v[SP_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (lvl_s1[i] != last_q[i])
				cnt_n[i] = '0;
			else if (cnt_q[i] == '1)
				cnt_n[i] = cnt_q[i];
			else
				cnt_n[i] = cnt_q[i] + HOLD_COUNT_BITS'(1);
			if (cnt_n[i] > {{(HOLD_COUNT_BITS-DEB_W){1'b0}}, debounce_q}
					&& lvl_s1[i] != stable_q[i]) begin
				stable_n[i] = lvl_s1[i];
				press[i]    = !lvl_s1[i];
			end else begin
				stable_n[i] = stable_q[i];
				press[i]    = 1'b0;
			end
		end

		sp_a   = press[BTN_DOWN] ? move_sp(sp_q, 1'b0, sp_min_q, sp_max_q) : sp_q;
		sp_n   = press[BTN_UP] ? move_sp(sp_a, 1'b1, sp_min_q, sp_max_q) : sp_a;
		mode_b = press[BTN_MODE] ? next_mode(mode_q) : mode_q;
		fan_b  = fan_forced_q ^ press[BTN_FAN];
		mode_n = mode_b;
		fan_forced_n = fan_b;

		case (cmd_s1)
			CMD_NONE: begin
			end
			CMD_PRESET_HEAT: begin
				sp_n = PRESET_HEAT;
				mode_n = MODE_HEAT;
				fan_forced_n = 1'b0;
			end
			CMD_PRESET_COOL: begin
				sp_n = PRESET_COOL;
				mode_n = MODE_COOL;
				fan_forced_n = 1'b0;
			end
			CMD_PRESET_OFF: begin
				sp_n = PRESET_OFF;
				mode_n = MODE_OFF;
				fan_forced_n = 1'b0;
			end
			default: begin
				mode_n = next_mode(mode_b);
				fan_forced_n = !fan_b;
			end
		endcase

		target   = {1'b0, sp_n, 3'b000} + {3'b000, sp_n, 1'b0};
		target_s = $signed({3'b000, target});
		t_plus   = $signed({temp_s1[TEMP_W-1], temp_s1}) + $signed({7'b0, deadband_q});
		t_minus  = $signed({temp_s1[TEMP_W-1], temp_s1}) - $signed({7'b0, deadband_q});
		heat_n = 1'b0;
		cool_n = 1'b0;
		fan_n  = 1'b0;
		case (mode_n)
			MODE_HEAT: begin
				heat_n = t_plus < target_s;
				fan_n  = heat_n || fan_forced_n;
			end
			MODE_COOL: begin
				cool_n = t_minus > target_s;
				fan_n  = cool_n || fan_forced_n;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			deadband_q <= DEADBAND_RST;
			sp_min_q   <= SP_MIN_RST;
			sp_max_q   <= SP_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data[DEB_W-1:0];
				CFG_DEADBAND: deadband_q <= cfg_data[DBAND_W-1:0];
				CFG_SP_MIN:   sp_min_q   <= cfg_data[SP_W-1:0];
				CFG_SP_MAX:   sp_max_q   <= cfg_data[SP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q       <= '0;
			stable_q     <= '0;
			sp_q         <= SP_RST;
			mode_q       <= MODE_OFF;
			fan_forced_q <= 1'b0;
			for (int i = 0; i < NUM_BUTTONS; i++)
				cnt_q[i] <= '0;
		end else if (advance) begin
			last_q       <= lvl_s1;
			stable_q     <= stable_n;
			sp_q         <= sp_n;
			mode_q       <= mode_n;
			fan_forced_q <= fan_forced_n;
			for (int i = 0; i < NUM_BUTTONS; i++)
				cnt_q[i] <= cnt_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			lvl_s1  <= {btn_fan_level, btn_mode_level, btn_up_level, btn_down_level};
			cmd_s1  <= remote_cmd;
			temp_s1 <= temp_tenths_f;
		end
		if (advance) begin
			heater_q         <= heat_n;
			cooler_q         <= cool_n;
			fan_q            <= fan_n;
			sp_out_q         <= sp_n;
			mode_out_q       <= mode_n;
			fan_forced_out_q <= fan_forced_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign heater_drive   = heater_q;
	assign cooler_drive   = cooler_q;
	assign fan_drive      = fan_q;
	assign setpoint_now   = sp_out_q;
	assign mode_now       = mode_out_q;
	assign fan_forced_now = fan_forced_out_q;

endmodule
`default_nettype wire

FILE: design/thcd_checker.sv
// Port-level checker for the deadband thermostat core, bound to the core module.
// Depends on thcd_pkg.
`default_nettype none
module thcd_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         out_valid,
	input wire                         out_stall,
	input wire                         heater_drive,
	input wire                         cooler_drive,
	input wire                         fan_drive,
	input wire [thcd_pkg::SP_W-1:0]    setpoint_now,
	input wire [1:0]                   mode_now
);
	import thcd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(setpoint_now))
		else $error("stalled output word dropped or changed");

	a_relay_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(heater_drive && cooler_drive))
		else $error("heater and cooler driven together");

	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_now == MODE_OFF |-> !heater_drive && !cooler_drive && !fan_drive)
		else $error("relay driven while system off");

	a_heat_fan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && heater_drive |-> fan_drive && mode_now == MODE_HEAT)
		else $error("heater without fan or outside heat mode");

	a_cool_fan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cooler_drive |-> fan_drive && mode_now == MODE_COOL)
		else $error("cooler without fan or outside cool mode");

endmodule

bind thermostat_controller_deadband_core thcd_checker u_thcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.heater_drive (heater_drive),
	.cooler_drive (cooler_drive),
	.fan_drive    (fan_drive),
	.setpoint_now (setpoint_now),
	.mode_now     (mode_now)
);
`default_nettype wire
